FILE: design/bscr_pkg.sv
// Shared types, codes and constants for the six-step commutation driver.
package bscr_pkg;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_HALL  = 2'd0;
   localparam kind_type KIND_TICK  = 2'd1;
   localparam kind_type KIND_ADC   = 2'd2;
   localparam kind_type KIND_START = 2'd3;

   typedef logic [1:0] mode_type;
   localparam mode_type MODE_STOPPED = 2'd0;
   localparam mode_type MODE_START   = 2'd1;
   localparam mode_type MODE_RUN     = 2'd2;

   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_DIRECTION       = 3'd0;
   localparam csr_index_type CSR_PWM_PERIOD      = 3'd1;
   localparam csr_index_type CSR_MIN_DUTY        = 3'd2;
   localparam csr_index_type CSR_RAMP_HOLD       = 3'd3;
   localparam csr_index_type CSR_SAMPLE_INTERVAL = 3'd4;
   localparam csr_index_type CSR_RUN_SLEW_STEP   = 3'd5;

   localparam logic [15:0] RESET_PWM_PERIOD      = 16'd800;
   localparam logic [15:0] RESET_MIN_DUTY        = 16'd80;
   localparam logic [15:0] RESET_RAMP_HOLD       = 16'd10;
   localparam logic [15:0] RESET_SAMPLE_INTERVAL = 16'd100;
   localparam logic [7:0]  RESET_RUN_SLEW_STEP   = 8'd1;

   // soft-start divides the duty gap by 2**STARTUP_STEP_LOG2
   localparam int STARTUP_STEP_LOG2  = 4;
   localparam int STARTUP_STEP_COUNT = 1 << STARTUP_STEP_LOG2;

   localparam logic [9:0] ADC_OFF_LEVEL = 10'd1000;
   localparam logic [9:0] ADC_DEADBAND  = 10'd10;

   typedef struct packed {
      logic        direction;
      logic [15:0] pwm_period;
      logic [15:0] min_duty;
      logic [15:0] ramp_hold_ticks;
      logic [15:0] sample_interval_ticks;
      logic [7:0]  run_slew_step;
   } cfg_type;

   typedef struct packed {
      kind_type   kind;
      logic [2:0] hall;
      logic [9:0] adc_value;
   } req_type;

   typedef struct packed {
      logic [7:0]  gate_pattern;
      logic [15:0] compare_value;
      logic        pwm_output_on;
      logic        sample_request;
      mode_type    motor_state;
   } rsp_type;

   // high sides on bits 7/5/3, low sides on bits 6/4/2; invalid codes give zero
   function automatic logic [7:0] gate_lookup(input logic direction, input logic [2:0] hall);
      logic [7:0] pat;
      pat = 8'h00;
      if (!direction) begin
         case (hall)
            3'd1: pat = 8'h60;
            3'd2: pat = 8'h18;
            3'd3: pat = 8'h48;
            3'd4: pat = 8'h84;
            3'd5: pat = 8'h24;
            3'd6: pat = 8'h90;
            default: pat = 8'h00;
         endcase
      end else begin
         case (hall)
            3'd1: pat = 8'h90;
            3'd2: pat = 8'h24;
            3'd3: pat = 8'h84;
            3'd4: pat = 8'h48;
            3'd5: pat = 8'h18;
            3'd6: pat = 8'h60;
            default: pat = 8'h00;
         endcase
      end
      return pat;
   endfunction

endpackage

FILE: design/bscr_csr.sv
// Configuration register file with write port.
module bscr_csr
   import bscr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write_enable,
   input  csr_index_type csr_index,
   input  logic [15:0]   csr_write_data,
   output cfg_type       cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DIRECTION:       cfg_in.direction             = csr_write_data[0];
            CSR_PWM_PERIOD:      cfg_in.pwm_period            = csr_write_data;
            CSR_MIN_DUTY:        cfg_in.min_duty              = csr_write_data;
            CSR_RAMP_HOLD:       cfg_in.ramp_hold_ticks       = csr_write_data;
            CSR_SAMPLE_INTERVAL: cfg_in.sample_interval_ticks = csr_write_data;
            CSR_RUN_SLEW_STEP:   cfg_in.run_slew_step         = csr_write_data[7:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.direction             <= 1'b0;
         cfg_ff.pwm_period            <= RESET_PWM_PERIOD;
         cfg_ff.min_duty              <= RESET_MIN_DUTY;
         cfg_ff.ramp_hold_ticks       <= RESET_RAMP_HOLD;
         cfg_ff.sample_interval_ticks <= RESET_SAMPLE_INTERVAL;
         cfg_ff.run_slew_step         <= RESET_RUN_SLEW_STEP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: design/bscr_duty.sv
// ADC to duty scaling: floor(adc * period / 1023) or floor(adc * period / 1025).
module bscr_duty
   import bscr_pkg::*;
(
   input  logic [9:0]  adc_value,
   input  logic [15:0] pwm_period,
   input  logic        div_1025,
   output logic [15:0] duty
);

   logic [25:0] product;
   logic [27:0] x;
   logic [27:0] t_lo;
   logic [27:0] t_hi;
   logic [27:0] q_lo_est;
   logic [27:0] q_hi_est;
   logic [27:0] r_lo;
   logic [28:0] r_hi;
   logic [27:0] q_lo;
   logic [27:0] q_hi;

   assign product = adc_value * pwm_period;
   assign x       = {2'b00, product};

   // 1/1023 ~ 2^-10 + 2^-20 ; estimate is exact or one low
   assign t_lo     = x + (x >> 10) + (x >> 20);
   assign q_lo_est = t_lo >> 10;
   assign r_lo     = x + q_lo_est - (q_lo_est << 10);
   assign q_lo     = (r_lo >= 28'd1023) ? q_lo_est + 28'd1 : q_lo_est;

   // 1/1025 ~ 2^-10 - 2^-20 ; estimate is within one either way, signed remainder
   assign t_hi     = x - (x >> 10) + (x >> 20);
   assign q_hi_est = t_hi >> 10;
   assign r_hi     = {1'b0, x} - {1'b0, q_hi_est << 10} - {1'b0, q_hi_est};
   assign q_hi     = r_hi[28] ? q_hi_est - 28'd1
                   : ((r_hi >= 29'd1025) ? q_hi_est + 28'd1 : q_hi_est);

   assign duty = div_1025 ? q_hi[15:0] : q_lo[15:0];

endmodule

FILE: design/bscr_core.sv
// Commutation, soft-start ramp and run slew state with next-result logic.
module bscr_core
   import bscr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    process,
   input  req_type req,
   output rsp_type rsp
);

   logic [7:0]  gate_ff, gate_in;
   logic [15:0] current_ff, current_in;
   logic [15:0] compare_ff, compare_in;
   logic [15:0] desired_ff, desired_in;
   logic [15:0] ramp_step_ff, ramp_step_in;
   mode_type    mode_ff, mode_in;
   logic [15:0] ramp_cnt_ff, ramp_cnt_in;
   logic [15:0] sample_cnt_ff, sample_cnt_in;
   logic [9:0]  last_adc_ff, last_adc_in;
   logic        pwm_on_ff, pwm_on_in;
   logic        request;

   logic [15:0] duty;
   logic [7:0]  hall_pat;
   logic [7:0]  gate_new;
   logic        below_min;
   logic        adc_high;
   logic        pwm_off;
   logic [15:0] desired_set;
   logic [15:0] start_gap;
   logic [15:0] start_step;
   logic        adc_moved;
   logic [15:0] ramp_cnt_inc;
   logic [15:0] sample_cnt_inc;
   logic [16:0] ramp_sum;
   logic [15:0] ramp_duty;
   logic [15:0] top;
   logic [16:0] slew_sum;
   logic [15:0] slew_up;
   logic [15:0] slew_down;

   bscr_duty u_duty (
      .adc_value  (req.adc_value),
      .pwm_period (cfg.pwm_period),
      .div_1025   (req.kind == KIND_ADC),
      .duty       (duty)
   );

   assign hall_pat    = gate_lookup(cfg.direction, req.hall);
   assign gate_new    = (hall_pat != 8'h00) ? hall_pat : gate_ff;
   assign below_min   = duty < cfg.min_duty;
   assign adc_high    = req.adc_value >= ADC_OFF_LEVEL;
   assign pwm_off     = !below_min && adc_high;
   assign desired_set = below_min ? cfg.min_duty : (adc_high ? desired_ff : duty);
   assign start_gap   = desired_set - current_ff;
   assign start_step  = start_gap >> STARTUP_STEP_LOG2;
   assign adc_moved   = ({1'b0, req.adc_value} > {1'b0, last_adc_ff} + {1'b0, ADC_DEADBAND})
                     || ({1'b0, req.adc_value} + {1'b0, ADC_DEADBAND} < {1'b0, last_adc_ff});

   assign ramp_cnt_inc   = (ramp_cnt_ff == 16'hFFFF) ? ramp_cnt_ff : ramp_cnt_ff + 16'd1;
   assign sample_cnt_inc = (sample_cnt_ff == 16'hFFFF) ? sample_cnt_ff : sample_cnt_ff + 16'd1;
   assign ramp_sum       = {1'b0, current_ff} + {1'b0, ramp_step_ff};
   assign ramp_duty      = ramp_sum[16] ? 16'hFFFF : ramp_sum[15:0];
   assign top            = (cfg.pwm_period == 16'd0) ? 16'd0 : cfg.pwm_period - 16'd1;
   assign slew_sum       = {1'b0, current_ff} + {9'd0, cfg.run_slew_step};
   assign slew_up        = slew_sum[16] ? 16'hFFFF : slew_sum[15:0];
   assign slew_down      = (current_ff > {8'd0, cfg.run_slew_step})
                         ? current_ff - {8'd0, cfg.run_slew_step} : 16'd0;

   always_comb begin
      gate_in       = gate_ff;
      current_in    = current_ff;
      compare_in    = compare_ff;
      desired_in    = desired_ff;
      ramp_step_in  = ramp_step_ff;
      mode_in       = mode_ff;
      ramp_cnt_in   = ramp_cnt_ff;
      sample_cnt_in = sample_cnt_ff;
      last_adc_in   = last_adc_ff;
      pwm_on_in     = pwm_on_ff;
      request       = 1'b0;
      unique case (req.kind)
         KIND_HALL: begin
            gate_in = gate_new;
         end
         KIND_START: begin
            last_adc_in = req.adc_value;
            desired_in  = desired_set;
            if (pwm_off) begin
               pwm_on_in = 1'b0;
            end
            gate_in = gate_new;
            if (current_ff < desired_set) begin
               ramp_step_in = (start_step == 16'd0) ? 16'd1 : start_step;
               mode_in      = MODE_START;
            end else begin
               mode_in = MODE_RUN;
            end
         end
         KIND_ADC: begin
            if (adc_moved) begin
               last_adc_in = req.adc_value;
               pwm_on_in   = !pwm_off;
               desired_in  = desired_set;
            end
         end
         KIND_TICK: begin
            ramp_cnt_in   = ramp_cnt_inc;
            sample_cnt_in = sample_cnt_inc;
            unique case (mode_ff)
               MODE_START: begin
                  if (ramp_cnt_inc > cfg.ramp_hold_ticks && current_ff < desired_ff) begin
                     current_in  = ramp_duty;
                     compare_in  = (ramp_duty > top) ? top : ramp_duty;
                     ramp_cnt_in = 16'd0;
                  end else if (current_ff >= desired_ff) begin
                     mode_in = MODE_RUN;
                  end
               end
               MODE_RUN: begin
                  if (sample_cnt_inc > cfg.sample_interval_ticks) begin
                     sample_cnt_in = 16'd0;
                     request       = 1'b1;
                  end
                  if (desired_ff > current_ff) begin
                     current_in = slew_up;
                     compare_in = slew_up;
                  end else if (desired_ff < current_ff) begin
                     current_in = slew_down;
                     compare_in = slew_down;
                  end else begin
                     compare_in = current_ff;
                  end
               end
               default: begin
                  mode_in = mode_ff;
               end
            endcase
         end
         default: begin
            gate_in = gate_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_ff       <= 8'h00;
         current_ff    <= RESET_MIN_DUTY;
         compare_ff    <= RESET_MIN_DUTY;
         desired_ff    <= 16'd0;
         ramp_step_ff  <= 16'd0;
         mode_ff       <= MODE_STOPPED;
         ramp_cnt_ff   <= 16'd0;
         sample_cnt_ff <= 16'd0;
         last_adc_ff   <= 10'd0;
         pwm_on_ff     <= 1'b1;
      end else if (process) begin
         gate_ff       <= gate_in;
         current_ff    <= current_in;
         compare_ff    <= compare_in;
         desired_ff    <= desired_in;
         ramp_step_ff  <= ramp_step_in;
         mode_ff       <= mode_in;
         ramp_cnt_ff   <= ramp_cnt_in;
         sample_cnt_ff <= sample_cnt_in;
         last_adc_ff   <= last_adc_in;
         pwm_on_ff     <= pwm_on_in;
      end
   end

   assign rsp.gate_pattern   = gate_in;
   assign rsp.compare_value  = compare_in;
   assign rsp.pwm_output_on  = pwm_on_in;
   assign rsp.sample_request = request;
   assign rsp.motor_state    = mode_in;

endmodule

FILE: design/bldc_six_step_commutation_ramp.sv
// Top level: six-step hall commutation driver with soft-start duty ramp.
// A request in the request register passes to the result register when the
// output can advance: one request per cycle unless a stalled result is held,
// each updating state in a single pass between the two registers.
// Reset (synchronous, active high) empties both registers, restores register
// defaults and returns the drive state to stopped with duty at the minimum.
module bldc_six_step_commutation_ramp
   import bscr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [1:0]    req_kind,
   input  logic [2:0]    req_hall,
   input  logic [9:0]    req_adc_value,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [7:0]    rsp_gate_pattern,
   output logic [15:0]   rsp_compare_value,
   output logic          rsp_pwm_output_on,
   output logic          rsp_sample_request,
   output logic [1:0]    rsp_motor_state,
   input  logic          csr_write_enable,
   input  csr_index_type csr_index,
   input  logic [15:0]   csr_write_data
);

   cfg_type cfg;
   logic    req_valid_ff, req_valid_in;
   req_type req_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_next;
   logic    advance;
   logic    process;
   logic    accept;

   bscr_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   bscr_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .process (process),
      .req     (req_ff),
      .rsp     (rsp_next)
   );

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign process   = req_valid_ff && advance;
   assign req_stall = req_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign req_valid_in = accept || (req_valid_ff && !process);
   assign rsp_valid_in = process || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff.kind      <= req_kind;
         req_ff.hall      <= req_hall;
         req_ff.adc_value <= req_adc_value;
      end
      if (process) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_gate_pattern   = rsp_ff.gate_pattern;
   assign rsp_compare_value  = rsp_ff.compare_value;
   assign rsp_pwm_output_on  = rsp_ff.pwm_output_on;
   assign rsp_sample_request = rsp_ff.sample_request;
   assign rsp_motor_state    = rsp_ff.motor_state;

endmodule

FILE: test/bldc_six_step_commutation_ramp_tb.sv
// Self-checking testbench for the six-step commutation driver with soft-start ramp.
`timescale 1ns / 1ps

module bldc_six_step_commutation_ramp_tb;
   import bscr_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int unsigned START_SCALE = 1023;
   localparam int unsigned ADC_SCALE = 1025;
   localparam csr_index_type CSR_SPARE_LO = 3'd6;
   localparam csr_index_type CSR_SPARE_HI = 3'd7;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   logic [1:0]    req_kind;
   logic [2:0]    req_hall;
   logic [9:0]    req_adc_value;
   logic          rsp_valid;
   logic          rsp_stall;
   logic [7:0]    rsp_gate_pattern;
   logic [15:0]   rsp_compare_value;
   logic          rsp_pwm_output_on;
   logic          rsp_sample_request;
   logic [1:0]    rsp_motor_state;
   logic          csr_write_enable;
   csr_index_type csr_index;
   logic [15:0]   csr_write_data;

   bldc_six_step_commutation_ramp dut (.*);

   // drive model state
   cfg_type     cfg_q;
   logic [7:0]  gate_q;
   logic [15:0] duty_now;
   logic [15:0] compare_q;
   logic [15:0] duty_target;
   logic [15:0] ramp_inc;
   mode_type    mode_q;
   logic [15:0] ramp_cnt;
   logic [15:0] sample_cnt;
   logic [9:0]  adc_last;
   logic        pwm_en;

   rsp_type expected_rsp[$];
   int      fail_count = 0;
   int      idle_cycles = 0;
   int      stall_left = 0;
   int      adc_level = 0;
   bit      src_gaps = 1'b1;
   bit      sink_gaps = 1'b1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] commutation(input logic dir, input logic [2:0] hall);
      case ({dir, hall})
         4'b0_001: return 8'h60;
         4'b0_010: return 8'h18;
         4'b0_011: return 8'h48;
         4'b0_100: return 8'h84;
         4'b0_101: return 8'h24;
         4'b0_110: return 8'h90;
         4'b1_001: return 8'h90;
         4'b1_010: return 8'h24;
         4'b1_011: return 8'h84;
         4'b1_100: return 8'h48;
         4'b1_101: return 8'h18;
         4'b1_110: return 8'h60;
         default: return 8'h00;
      endcase
   endfunction

   task automatic set_duty_target(input logic [9:0] adc, input int unsigned divisor);
      int unsigned scaled;
      scaled = (32'(adc) * 32'(cfg_q.pwm_period)) / divisor;
      if (scaled < 32'(cfg_q.min_duty)) begin
         duty_target = cfg_q.min_duty;
      end else if (adc >= ADC_OFF_LEVEL) begin
         pwm_en = 1'b0;
      end else begin
         duty_target = scaled[15:0];
      end
   endtask

   task automatic predict_drive(input kind_type kind, input logic [2:0] hall,
                                input logic [9:0] adc);
      logic [7:0]  pat;
      logic [16:0] duty_sum;
      logic [15:0] top;
      logic        request;
      rsp_type     want;
      request = 1'b0;
      case (kind)
         KIND_HALL: begin
            pat = commutation(cfg_q.direction, hall);
            if (pat != 8'h00) gate_q = pat;
         end
         KIND_START: begin
            adc_last = adc;
            set_duty_target(adc, START_SCALE);
            pat = commutation(cfg_q.direction, hall);
            if (pat != 8'h00) gate_q = pat;
            if (duty_now < duty_target) begin
               ramp_inc = 16'((duty_target - duty_now) / STARTUP_STEP_COUNT);
               if (ramp_inc == 16'd0) ramp_inc = 16'd1;
               mode_q = MODE_START;
            end else begin
               mode_q = MODE_RUN;
            end
         end
         KIND_ADC: begin
            if (32'(adc) > 32'(adc_last) + 32'(ADC_DEADBAND) ||
                32'(adc) + 32'(ADC_DEADBAND) < 32'(adc_last)) begin
               adc_last = adc;
               pwm_en = 1'b1;
               set_duty_target(adc, ADC_SCALE);
            end
         end
         default: begin
            if (sample_cnt != 16'hFFFF) sample_cnt = sample_cnt + 16'd1;
            if (ramp_cnt != 16'hFFFF) ramp_cnt = ramp_cnt + 16'd1;
            if (mode_q == MODE_START) begin
               if (ramp_cnt > cfg_q.ramp_hold_ticks && duty_now < duty_target) begin
                  top = (cfg_q.pwm_period == 16'd0) ? 16'd0 : cfg_q.pwm_period - 16'd1;
                  duty_sum = {1'b0, duty_now} + {1'b0, ramp_inc};
                  duty_now = duty_sum[16] ? 16'hFFFF : duty_sum[15:0];
                  compare_q = (duty_now > top) ? top : duty_now;
                  ramp_cnt = 16'd0;
               end else if (duty_now >= duty_target) begin
                  mode_q = MODE_RUN;
               end
            end else if (mode_q == MODE_RUN) begin
               if (sample_cnt > cfg_q.sample_interval_ticks) begin
                  sample_cnt = 16'd0;
                  request = 1'b1;
               end
               if (duty_target > duty_now) begin
                  duty_sum = {1'b0, duty_now} + 17'(cfg_q.run_slew_step);
                  duty_now = duty_sum[16] ? 16'hFFFF : duty_sum[15:0];
               end else if (duty_target < duty_now) begin
                  duty_now = (duty_now > 16'(cfg_q.run_slew_step)) ?
                             duty_now - 16'(cfg_q.run_slew_step) : 16'd0;
               end
               compare_q = duty_now;
            end
         end
      endcase
      want.gate_pattern = gate_q;
      want.compare_value = compare_q;
      want.pwm_output_on = pwm_en;
      want.sample_request = request;
      want.motor_state = mode_q;
      expected_rsp.push_back(want);
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         cfg_q.direction = 1'b0;
         cfg_q.pwm_period = RESET_PWM_PERIOD;
         cfg_q.min_duty = RESET_MIN_DUTY;
         cfg_q.ramp_hold_ticks = RESET_RAMP_HOLD;
         cfg_q.sample_interval_ticks = RESET_SAMPLE_INTERVAL;
         cfg_q.run_slew_step = RESET_RUN_SLEW_STEP;
         gate_q = 8'h00;
         duty_now = RESET_MIN_DUTY;
         compare_q = RESET_MIN_DUTY;
         duty_target = 16'd0;
         ramp_inc = 16'd0;
         mode_q = MODE_STOPPED;
         ramp_cnt = 16'd0;
         sample_cnt = 16'd0;
         adc_last = 10'd0;
         pwm_en = 1'b1;
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (csr_write_enable) begin
            idle_cycles = 0;
            case (csr_index)
               CSR_DIRECTION:       cfg_q.direction = csr_write_data[0];
               CSR_PWM_PERIOD:      cfg_q.pwm_period = csr_write_data;
               CSR_MIN_DUTY:        cfg_q.min_duty = csr_write_data;
               CSR_RAMP_HOLD:       cfg_q.ramp_hold_ticks = csr_write_data;
               CSR_SAMPLE_INTERVAL: cfg_q.sample_interval_ticks = csr_write_data;
               CSR_RUN_SLEW_STEP:   cfg_q.run_slew_step = csr_write_data[7:0];
               default: ;
            endcase
         end
         if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            idle_cycles = 0;
            if (expected_rsp.size() == 0) begin
               fail_count++;
               $display("%0t: result with no request pending, actual gate %0h compare %0h",
                        $time, rsp_gate_pattern, rsp_compare_value);
            end else begin
               want = expected_rsp.pop_front();
               check_field("gate_pattern", 16'(want.gate_pattern), 16'(rsp_gate_pattern));
               check_field("compare_value", want.compare_value, rsp_compare_value);
               check_field("pwm_output_on", 16'(want.pwm_output_on),
                           16'(rsp_pwm_output_on));
               check_field("sample_request", 16'(want.sample_request),
                           16'(rsp_sample_request));
               check_field("motor_state", 16'(want.motor_state), 16'(rsp_motor_state));
            end
         end
         if (req_valid && req_stall === 1'b0) begin
            idle_cycles = 0;
            predict_drive(req_kind, req_hall, req_adc_value);
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_stall = 1'b1;
         stall_left--;
      end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
         rsp_stall = 1'b1;
         stall_left = int'($urandom_range(0, 2));
      end else begin
         rsp_stall = 1'b0;
      end
   end

   // all tasks below start and end just after a falling edge
   task automatic send_request(input kind_type kind, input logic [2:0] hall,
                               input logic [9:0] adc);
      if (src_gaps && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_kind = kind;
      req_hall = hall;
      req_adc_value = adc;
      do @(posedge clock); while (req_stall !== 1'b0);
      @(negedge clock);
   endtask

   task automatic wait_until_quiet();
      req_valid = 1'b0;
      while (expected_rsp.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [15:0] data);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic configure(input logic dir, input logic [15:0] period, min_level, hold,
                            interval, input logic [7:0] slew);
      wait_until_quiet();
      write_csr(CSR_DIRECTION, {15'($urandom), dir});
      write_csr(CSR_PWM_PERIOD, period);
      write_csr(CSR_MIN_DUTY, min_level);
      write_csr(CSR_RAMP_HOLD, hold);
      write_csr(CSR_SAMPLE_INTERVAL, interval);
      write_csr(CSR_RUN_SLEW_STEP, {8'($urandom), slew});
   endtask

   function automatic logic [2:0] pick_hall();
      return ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(1, 6));
   endfunction

   function automatic logic [9:0] pick_adc();
      int sel;
      int v;
      sel = int'($urandom_range(0, 9));
      if (sel < 6) begin
         v = int'($urandom_range(0, 50)) - 25 + adc_level;
         if (v < 0) v = 0;
         if (v > 1023) v = 1023;
      end else if (sel < 9) begin
         v = int'($urandom_range(0, 1023));
      end else begin
         v = int'($urandom_range(1000, 1023));
      end
      adc_level = v;
      return 10'(v);
   endfunction

   // start the motor, then a mix weighted toward PWM ticks
   task automatic run_drive_traffic(input int count);
      int pick;
      send_request(KIND_START, 3'($urandom_range(1, 6)), 10'($urandom_range(0, 999)));
      repeat (count) begin
         pick = int'($urandom_range(0, 99));
         if (pick < 55) send_request(KIND_TICK, 3'($urandom), 10'($urandom));
         else if (pick < 72) send_request(KIND_HALL, pick_hall(), 10'($urandom));
         else if (pick < 92) send_request(KIND_ADC, 3'($urandom), pick_adc());
         else send_request(KIND_START, pick_hall(), pick_adc());
      end
   endtask

   task automatic configure_random();
      configure(1'($urandom),
                ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                            : 16'($urandom_range(50, 2000)),
                16'($urandom_range(0, 300)), 16'($urandom_range(0, 4)),
                16'($urandom_range(0, 20)),
                ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 8))
                                            : 8'($urandom_range(1, 255)));
   endtask

   task automatic test_commutation_table();
      write_csr(CSR_DIRECTION, 16'h0000);
      for (int h = 0; h < 8; h++) send_request(KIND_HALL, 3'(h), 10'($urandom));
      wait_until_quiet();
      write_csr(CSR_DIRECTION, 16'hFFFF);
      write_csr(CSR_SPARE_LO, 16'($urandom));
      write_csr(CSR_SPARE_HI, 16'hFFFF);
      for (int h = 1; h < 7; h++) send_request(KIND_HALL, 3'(h), 10'($urandom));
      send_request(KIND_HALL, 3'd7, 10'($urandom));
   endtask

   task automatic test_start_and_adc();
      send_request(KIND_START, 3'd1, 10'd0);
      send_request(KIND_TICK, 3'd0, 10'd0);
      send_request(KIND_START, 3'd2, 10'd1023);
      send_request(KIND_ADC, 3'd7, 10'd1015);
      send_request(KIND_ADC, 3'd0, 10'd1012);
      send_request(KIND_ADC, 3'd0, 10'd5);
      send_request(KIND_ADC, 3'd0, 10'd15);
      send_request(KIND_ADC, 3'd0, 10'd16);
      send_request(KIND_START, 3'd3, 10'd700);
      repeat (3) send_request(KIND_TICK, 3'd7, 10'h3FF);
   endtask

   task automatic test_soft_start_ramp();
      configure(1'b0, 16'd800, 16'd80, 16'd1, 16'd8, 8'd4);
      run_drive_traffic(60);
   endtask

   task automatic test_low_extremes();
      configure(1'b1, 16'd1, 16'd0, 16'd0, 16'd0, 8'd255);
      run_drive_traffic(50);
   endtask

   task automatic test_duty_saturation();
      configure(1'b0, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 8'd255);
      run_drive_traffic(40);
      configure(1'b1, 16'hFFFF, 16'hFFFF, 16'd2, 16'hFFFF, 8'd255);
      run_drive_traffic(40);
   endtask

   task automatic test_random_settings();
      repeat (3) begin
         configure_random();
         run_drive_traffic(40);
      end
   endtask

   task automatic test_counter_saturation();
      configure(1'b0, 16'd800, 16'd80, 16'hFFFF, 16'hFFFF, 8'd1);
      send_request(KIND_START, 3'd4, 10'd900);
      repeat (20) send_request(KIND_TICK, 3'($urandom), 10'($urandom));
      configure(1'b1, 16'd800, 16'd80, 16'd100, 16'd10, 8'd1);
      repeat (2) send_request(KIND_TICK, 3'd0, 10'd0);
      send_request(KIND_START, 3'd5, 10'd0);
      repeat (2) send_request(KIND_TICK, 3'd0, 10'd0);
   endtask

   task automatic test_final_traffic();
      configure_random();
      run_drive_traffic(60);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_HALL;
      req_hall = 3'd0;
      req_adc_value = 10'd0;
      rsp_stall = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = CSR_DIRECTION;
      csr_write_data = 16'd0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      test_commutation_table();
      test_start_and_adc();
      test_soft_start_ramp();
      test_low_extremes();
      test_duty_saturation();
      test_random_settings();
      src_gaps = 1'b0;
      sink_gaps = 1'b0;
      test_counter_saturation();
      test_final_traffic();

      wait_until_quiet();
      repeat (6) @(negedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
design/bscr_pkg.sv
design/bscr_csr.sv
design/bscr_duty.sv
design/bscr_core.sv
design/bldc_six_step_commutation_ramp.sv
test/bldc_six_step_commutation_ramp_tb.sv
